FILE: design/gmiq_pkg.sv
// Shared widths, codes, lookup tables and item types of the grid incidence query block.
package gmiq_pkg;

  localparam int ID_W        = 21;
  localparam int DIM_REG_W   = 11;
  localparam int MAX_DIM_DEF = 1024;
  localparam int CFG_ADDR_W  = 2;
  localparam int DIV_STEPS   = 3;
  localparam int QDEPTH      = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DIM_X  = 2'd0,
    CFG_DIM_Y  = 2'd1,
    CFG_WRAP_X = 2'd2,
    CFG_WRAP_Y = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_NODE = 3'd0,
    KIND_EDGE = 3'd1,
    KIND_FACE = 3'd2,
    KIND_CELL = 3'd3,
    KIND_BAD  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_st_t;

  localparam logic signed [1:0] ORI_NONE = 2'sb00;
  localparam logic signed [1:0] ORI_POS  = 2'sb01;
  localparam logic signed [1:0] ORI_NEG  = 2'sb11;

  // orientation of each edge of a face, and of each face of an edge
  localparam logic signed [1:0] FACE_EDGE_ORI [4] = '{ORI_POS, ORI_POS, ORI_NEG, ORI_NEG};
  localparam logic signed [1:0] EDGE_FACE_ORI [2][2] =
    '{'{ORI_POS, ORI_NEG}, '{ORI_NEG, ORI_POS}};
  localparam logic [1:0] EDGE_FACE_SLOT [2][2] = '{'{2'd0, 2'd2}, '{2'd3, 2'd1}};

  // classified query: command, edge direction, node-only flag
  typedef struct packed {
    logic cmd;
    logic t;
    logic node_sel;
  } qry_t;

  // queue entry: query plus grid position to split
  typedef struct packed {
    qry_t            q;
    logic [ID_W-1:0] pos;
  } qent_t;

endpackage

FILE: design/gmiq_front.sv
// Front end: accepts query words, classifies them and buffers them in a short queue.
module gmiq_front
  import gmiq_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  output logic            in_rdy,
  input  logic            in_cmd,
  input  logic [ID_W-1:0] in_elem_id,
  input  logic            in_node_sel,
  output logic            deq_vld,
  input  logic            deq_rdy,
  output qent_t           deq
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  qent_t            q_mem [QDEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  qent_t            ent;
  logic             push, pop;

  // split the id into position and edge direction
  always_comb begin
    ent.q.cmd      = in_cmd;
    ent.q.t        = in_cmd & in_elem_id[0];
    ent.q.node_sel = in_node_sel;
    ent.pos        = in_cmd ? {1'b0, in_elem_id[ID_W-1:1]} : in_elem_id;
  end

  assign in_rdy  = (cnt_r != CNT_W'(QDEPTH));
  assign deq_vld = (cnt_r != '0);
  assign deq     = q_mem[rp_r];
  assign push    = in_vld && in_rdy;
  assign pop     = deq_vld && deq_rdy;

  // advance pointers and fill count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(QDEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(QDEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= ent;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QDEPTH))
    else $error("queue fill count above depth");

endmodule

FILE: design/gmiq_div.sv
// Iterative divider: splits a grid position into column and row, a few quotient bits a cycle.
module gmiq_div
  import gmiq_pkg::*;
#(
  parameter int EDIM_W = DIM_REG_W
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [EDIM_W-1:0] dx,
  input  logic              in_vld,
  output logic              in_rdy,
  input  qent_t             in_ent,
  output logic              res_vld,
  input  logic              res_rdy,
  output logic [EDIM_W-1:0] res_i,
  output logic [ID_W-1:0]   res_j,
  output qry_t              res_q
);

  localparam int CYC   = (ID_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PAD_W = CYC * DIV_STEPS;
  localparam int CNT_W = (CYC > 1) ? $clog2(CYC) : 1;

  div_st_t           st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [PAD_W-1:0]  quo_r;
  logic [EDIM_W-1:0] rem_r;
  qry_t              q_r;
  logic [EDIM_W:0]   r;
  logic [PAD_W-1:0]  qv;
  logic              load;

  // restoring division steps for this cycle
  always_comb begin
    r  = {1'b0, rem_r};
    qv = quo_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r  = {r[EDIM_W-1:0], qv[PAD_W-1]};
      qv = {qv[PAD_W-2:0], 1'b0};
      if (r >= {1'b0, dx}) begin
        r     = r - {1'b0, dx};
        qv[0] = 1'b1;
      end
    end
  end

  // sequence load, iterate and hold
  always_comb begin
    st_nxt  = st_r;
    in_rdy  = 1'b0;
    res_vld = 1'b0;
    unique case (st_r)
      DIV_IDLE: begin
        in_rdy = 1'b1;
        if (in_vld) begin
          st_nxt = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (cnt_r == CNT_W'(CYC - 1)) begin
          st_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        res_vld = 1'b1;
        in_rdy  = res_rdy;
        if (res_rdy) begin
          st_nxt = in_vld ? DIV_RUN : DIV_IDLE;
        end
      end
      default: st_nxt = DIV_IDLE;
    endcase
  end

  assign load = in_vld && in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DIV_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // load the dividend, then shift the quotient in
  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= PAD_W'(in_ent.pos);
      rem_r <= '0;
      cnt_r <= '0;
      q_r   <= in_ent.q;
    end else if (st_r == DIV_RUN) begin
      quo_r <= qv;
      rem_r <= r[EDIM_W-1:0];
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign res_i = rem_r;
  assign res_j = quo_r[ID_W-1:0];
  assign res_q = q_r;

  a_rem_below_dim: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == DIV_DONE && dx != '0) |-> (rem_r < dx))
    else $error("division remainder not below divisor");

  a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (st_r == DIV_RUN && cnt_r == '0))
    else $error("accepted word did not start division");

endmodule

FILE: design/gmiq_emit.sv
// Back end: checks the position, forms neighbor ids and streams the result words.
module gmiq_emit
  import gmiq_pkg::*;
#(
  parameter int EDIM_W = DIM_REG_W
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [EDIM_W-1:0] dx,
  input  logic [EDIM_W-1:0] dy,
  input  logic              wrap_x,
  input  logic              wrap_y,
  input  logic              d_vld,
  output logic              d_rdy,
  input  logic [EDIM_W-1:0] d_i,
  input  logic [ID_W-1:0]   d_j,
  input  qry_t              d_q,
  output logic              out_vld,
  input  logic              out_rdy,
  output kind_t             out_kind,
  output logic [ID_W-1:0]   out_ref,
  output logic signed [1:0] out_ori,
  output logic [1:0]        out_slot,
  output logic              out_last
);

  localparam int PROD_W = 2 * EDIM_W;
  localparam int IDX_W  = 4;

  typedef struct packed {
    logic              col_b;
    logic              row_b;
    kind_t             kind;
    logic              odd;
    logic signed [1:0] ori;
    logic [1:0]        slot;
    logic              last;
  } wsel_t;

  // pick column, row and tags of result word idx
  function automatic wsel_t word_sel(input logic [IDX_W-1:0] idx, input qry_t q,
                                     input logic bad);
    wsel_t w;
    w = '{col_b: 1'b0, row_b: 1'b0, kind: KIND_NODE, odd: 1'b0, ori: ORI_NONE,
          slot: 2'd0, last: 1'b0};
    if (bad) begin
      w.kind = KIND_BAD;
      w.last = 1'b1;
    end else if (!q.cmd) begin
      unique case (idx)
        4'd0: ;
        4'd1: w.col_b = 1'b1;
        4'd2: begin
          w.col_b = 1'b1;
          w.row_b = 1'b1;
        end
        4'd3: begin
          w.row_b = 1'b1;
          w.last  = q.node_sel;
        end
        4'd4: begin
          w.kind = KIND_EDGE;
          w.ori  = FACE_EDGE_ORI[0];
        end
        4'd5: begin
          w.kind  = KIND_EDGE;
          w.col_b = 1'b1;
          w.odd   = 1'b1;
          w.ori   = FACE_EDGE_ORI[1];
        end
        4'd6: begin
          w.kind  = KIND_EDGE;
          w.row_b = 1'b1;
          w.ori   = FACE_EDGE_ORI[2];
        end
        4'd7: begin
          w.kind = KIND_EDGE;
          w.odd  = 1'b1;
          w.ori  = FACE_EDGE_ORI[3];
        end
        default: begin
          w.kind = KIND_CELL;
          w.ori  = ORI_POS;
          w.last = 1'b1;
        end
      endcase
    end else begin
      unique case (idx[1:0])
        2'd0: ;
        2'd1: begin
          w.col_b = !q.t;
          w.row_b = q.t;
          w.last  = q.node_sel;
        end
        2'd2: begin
          w.kind = KIND_FACE;
          w.ori  = EDGE_FACE_ORI[q.t][0];
          w.slot = EDGE_FACE_SLOT[q.t][0];
        end
        default: begin
          w.kind  = KIND_FACE;
          w.col_b = q.t;
          w.row_b = !q.t;
          w.ori   = EDGE_FACE_ORI[q.t][1];
          w.slot  = EDGE_FACE_SLOT[q.t][1];
          w.last  = 1'b1;
        end
      endcase
    end
    return w;
  endfunction

  logic [EDIM_W-1:0] lim_x, lim_y, jn, ip, im, jp, jm, colb, rsel;
  logic              bad;

  logic              p_vld_r;
  qry_t              p_q_r;
  logic              p_bad_r;
  logic [EDIM_W-1:0] p_i_r, p_colb_r;
  logic [PROD_W-1:0] p_rowa_r, p_rowb_r;

  logic              s_vld_r;
  logic [IDX_W-1:0]  s_idx_r;
  qry_t              s_q_r;
  logic              s_bad_r;
  logic [EDIM_W-1:0] s_i_r, s_colb_r;
  logic [PROD_W-1:0] s_rowa_r, s_rowb_r;

  logic              out_vld_r;
  kind_t             out_kind_r;
  logic [ID_W-1:0]   out_ref_r;
  logic signed [1:0] out_ori_r;
  logic [1:0]        out_slot_r;
  logic              out_last_r;

  wsel_t             w;
  logic [EDIM_W-1:0] col;
  logic [PROD_W-1:0] row;
  logic [ID_W-1:0]   node, ref_id;
  logic              slot_free, emit, s_done, s_load, p_load;

  // bounds test and wrapped neighbor coordinates
  always_comb begin
    lim_x = wrap_x ? dx : dx - EDIM_W'(1);
    lim_y = wrap_y ? dy : dy - EDIM_W'(1);
    bad   = (dx == '0) || (dy == '0) || (d_i >= lim_x) || (d_j >= ID_W'(lim_y));
    jn    = d_j[EDIM_W-1:0];
    ip    = (d_i == dx - EDIM_W'(1)) ? '0 : d_i + EDIM_W'(1);
    im    = (d_i == '0) ? dx - EDIM_W'(1) : d_i - EDIM_W'(1);
    jp    = (jn == dy - EDIM_W'(1)) ? '0 : jn + EDIM_W'(1);
    jm    = (jn == '0) ? dy - EDIM_W'(1) : jn - EDIM_W'(1);
    colb  = (d_q.cmd && d_q.t) ? im : ip;
    rsel  = (d_q.cmd && !d_q.t) ? jm : jp;
  end

  // handshake between prep stage, word sequencer and output register
  assign slot_free = !out_vld_r || out_rdy;
  assign emit      = s_vld_r && slot_free;
  assign w         = word_sel(s_idx_r, s_q_r, s_bad_r);
  assign s_done    = emit && w.last;
  assign s_load    = p_vld_r && (!s_vld_r || s_done);
  assign d_rdy     = !p_vld_r || s_load;
  assign p_load    = d_vld && d_rdy;

  // form the id of the current word
  always_comb begin
    col    = w.col_b ? s_colb_r : s_i_r;
    row    = w.row_b ? s_rowb_r : s_rowa_r;
    node   = ID_W'(col) + ID_W'(row);
    ref_id = node;
    if (s_bad_r) begin
      ref_id = '0;
    end else if (w.kind == KIND_EDGE) begin
      ref_id = {node[ID_W-2:0], w.odd};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      s_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (p_load) begin
        p_vld_r <= 1'b1;
      end else if (s_load) begin
        p_vld_r <= 1'b0;
      end
      if (s_load) begin
        s_vld_r <= 1'b1;
      end else if (s_done) begin
        s_vld_r <= 1'b0;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_rdy) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // prep stage: validity, neighbor columns and row bases
  always_ff @(posedge clk) begin
    if (p_load) begin
      p_q_r    <= d_q;
      p_bad_r  <= bad;
      p_i_r    <= d_i;
      p_colb_r <= colb;
      p_rowa_r <= PROD_W'(dx) * PROD_W'(jn);
      p_rowb_r <= PROD_W'(dx) * PROD_W'(rsel);
    end
  end

  // sequencer: hold the query, advance the word index
  always_ff @(posedge clk) begin
    if (s_load) begin
      s_idx_r  <= '0;
      s_q_r    <= p_q_r;
      s_bad_r  <= p_bad_r;
      s_i_r    <= p_i_r;
      s_colb_r <= p_colb_r;
      s_rowa_r <= p_rowa_r;
      s_rowb_r <= p_rowb_r;
    end else if (emit) begin
      s_idx_r <= s_idx_r + IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= w.kind;
      out_ref_r  <= ref_id;
      out_ori_r  <= w.ori;
      out_slot_r <= w.slot;
      out_last_r <= w.last;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_kind = out_kind_r;
  assign out_ref  = out_ref_r;
  assign out_ori  = out_ori_r;
  assign out_slot = out_slot_r;
  assign out_last = out_last_r;

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    (s_vld_r && s_bad_r) |-> (s_idx_r == '0))
    else $error("invalid query sequenced past its single word");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s_vld_r |-> (s_idx_r <= IDX_W'(8)))
    else $error("word index beyond the ninth result");

endmodule

FILE: design/grid_mesh_incidence_query.sv
// Top level: configuration registers and the front, divider and emitter chain.
// Throughput: one result word per cycle while out_tready is high; a full face query gives 9
// result words, a full edge query 4, node-only queries 4 or 2; the column/row divider
// (7 iterations of 3 quotient bits) takes the next query only as it hands off its result,
// so it sets the pace for the short queries.
// Reset: dim_x = dim_y = 1024, no wrap, queue and pipeline empty; no clearing pass.
module grid_mesh_incidence_query
  import gmiq_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // elem_id[20:0], node_sel[21], zero pad
  input  logic                  in_tuser,   // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // ref_id[20:0], orientation[22:21],
                                            // local_slot[24:23], zero pad
  output logic [2:0]            out_tuser,  // kind
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DIM_REG_W-1:0]  cfg_data
);

  localparam int DMAX   = (MAX_DIM < (1 << DIM_REG_W) - 1) ? MAX_DIM : (1 << DIM_REG_W) - 1;
  localparam int EDIM_W = $clog2(DMAX + 1);

  logic [DIM_REG_W-1:0] dim_x_r, dim_y_r;
  logic                 wrap_x_r, wrap_y_r;
  logic [EDIM_W-1:0]    dx, dy;

  qent_t                deq;
  logic                 deq_vld, deq_rdy;
  logic                 d_vld, d_rdy;
  logic [EDIM_W-1:0]    d_i;
  logic [ID_W-1:0]      d_j;
  qry_t                 d_q;

  kind_t                o_kind;
  logic [ID_W-1:0]      o_ref;
  logic signed [1:0]    o_ori;
  logic [1:0]           o_slot;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r  <= DIM_REG_W'(1024);
      dim_y_r  <= DIM_REG_W'(1024);
      wrap_x_r <= 1'b0;
      wrap_y_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_DIM_X:  dim_x_r  <= cfg_data;
        CFG_DIM_Y:  dim_y_r  <= cfg_data;
        CFG_WRAP_X: wrap_x_r <= cfg_data[0];
        CFG_WRAP_Y: wrap_y_r <= cfg_data[0];
      endcase
    end
  end

  // clamp dimensions to the supported maximum
  assign dx = (dim_x_r > DIM_REG_W'(DMAX)) ? EDIM_W'(DMAX) : dim_x_r[EDIM_W-1:0];
  assign dy = (dim_y_r > DIM_REG_W'(DMAX)) ? EDIM_W'(DMAX) : dim_y_r[EDIM_W-1:0];

  gmiq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (in_tvalid),
    .in_rdy      (in_tready),
    .in_cmd      (in_tuser),
    .in_elem_id  (in_tdata[ID_W-1:0]),
    .in_node_sel (in_tdata[ID_W]),
    .deq_vld     (deq_vld),
    .deq_rdy     (deq_rdy),
    .deq         (deq)
  );

  gmiq_div #(.EDIM_W(EDIM_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .dx      (dx),
    .in_vld  (deq_vld),
    .in_rdy  (deq_rdy),
    .in_ent  (deq),
    .res_vld (d_vld),
    .res_rdy (d_rdy),
    .res_i   (d_i),
    .res_j   (d_j),
    .res_q   (d_q)
  );

  gmiq_emit #(.EDIM_W(EDIM_W)) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .dx       (dx),
    .dy       (dy),
    .wrap_x   (wrap_x_r),
    .wrap_y   (wrap_y_r),
    .d_vld    (d_vld),
    .d_rdy    (d_rdy),
    .d_i      (d_i),
    .d_j      (d_j),
    .d_q      (d_q),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_kind (o_kind),
    .out_ref  (o_ref),
    .out_ori  (o_ori),
    .out_slot (o_slot),
    .out_last (out_tlast)
  );

  // pack the result word
  assign out_tdata = {7'b0, o_slot, o_ori, o_ref};
  assign out_tuser = o_kind;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the grid mesh incidence query block.
`timescale 1ns / 100ps

module tb
  import gmiq_pkg::*;
();

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 30;

  // one expected result word
  typedef struct packed {
    kind_t                  kind;
    logic [ID_W-1:0]        ref_id;
    logic signed [1:0]      ori;
    logic [1:0]             slot;
    logic                   last;
  } incidence_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;   // elem_id[20:0], node_sel[21], zero pad
  logic                  in_tuser = 1'b0; // cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [31:0]           out_tdata;       // ref_id[20:0], orientation[22:21],
                                          // local_slot[24:23], zero pad
  logic [2:0]            out_tuser;       // kind
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_addr = CFG_DIM_X;
  logic [DIM_REG_W-1:0]  cfg_data = '0;

  // shadow copy of the grid registers
  logic [DIM_REG_W-1:0]  grid_dim_x = 11'd1024;
  logic [DIM_REG_W-1:0]  grid_dim_y = 11'd1024;
  logic                  grid_wrap_x = 1'b0;
  logic                  grid_wrap_y = 1'b0;

  incidence_t incidence_q[$];
  bit  idle_on = 1'b0;
  int  stall_left = 0;
  int  errors = 0;
  int  cycles = 0;
  int  queries_sent = 0;
  int  bad_queries = 0;
  int  words_checked = 0;
  int  grids_used = 0;

  grid_mesh_incidence_query DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d result words still pending", $time, incidence_q.size());
      $display("grid_mesh_incidence_query verification failed");
      $finish;
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (!rst_n || !idle_on) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else begin
      if (stall_left == 0 && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic int eff_dim(logic [DIM_REG_W-1:0] v);
    return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(v);
  endfunction

  function automatic logic [ID_W-1:0] grid_point(int i, int j, int dx);
    return ID_W'(i + dx * j);
  endfunction

  function automatic void push_incidence(kind_t k, logic [ID_W-1:0] id,
                                         logic signed [1:0] o, logic [1:0] s, logic l);
    incidence_t w;
    w.kind = k;
    w.ref_id = id;
    w.ori = o;
    w.slot = s;
    w.last = l;
    incidence_q.insert(incidence_q.size(), w);
  endfunction

  // Work out every result word of one accepted query
  function automatic void predict_incidence(logic cmd, logic [ID_W-1:0] id, logic node_sel);
    int dx, dy, pos, i, j, ip, jp, lim_x, lim_y, t, p;
    logic [ID_W-1:0] face_ids [2];
    logic [ID_W-1:0] edge_ids [4];
    dx = eff_dim(grid_dim_x);
    dy = eff_dim(grid_dim_y);
    queries_sent++;
    if (dx == 0 || dy == 0) begin
      bad_queries++;
      push_incidence(KIND_BAD, '0, ORI_NONE, 2'd0, 1'b1);
      return;
    end
    t = cmd ? int'(id[0]) : 0;
    pos = cmd ? int'(id >> 1) : int'(id);
    j = pos / dx;
    i = pos - j * dx;
    lim_x = grid_wrap_x ? dx : dx - 1;
    lim_y = grid_wrap_y ? dy : dy - 1;
    if (i >= lim_x || j >= lim_y) begin
      bad_queries++;
      push_incidence(KIND_BAD, '0, ORI_NONE, 2'd0, 1'b1);
      return;
    end
    ip = (i + 1) % dx;
    jp = (j + 1) % dy;
    if (!cmd) begin
      // face: corner nodes, edges, containing cell
      push_incidence(KIND_NODE, grid_point(i, j, dx), ORI_NONE, 2'd0, 1'b0);
      push_incidence(KIND_NODE, grid_point(ip, j, dx), ORI_NONE, 2'd0, 1'b0);
      push_incidence(KIND_NODE, grid_point(ip, jp, dx), ORI_NONE, 2'd0, 1'b0);
      push_incidence(KIND_NODE, grid_point(i, jp, dx), ORI_NONE, 2'd0, node_sel);
      if (node_sel)
        return;
      edge_ids[0] = ID_W'(2 * (i + dx * j));
      edge_ids[1] = ID_W'(2 * (ip + dx * j) + 1);
      edge_ids[2] = ID_W'(2 * (i + dx * jp));
      edge_ids[3] = ID_W'(2 * (i + dx * j) + 1);
      for (p = 0; p < 4; p++)
        push_incidence(KIND_EDGE, edge_ids[p], FACE_EDGE_ORI[p], 2'd0, 1'b0);
      push_incidence(KIND_CELL, grid_point(i, j, dx), ORI_POS, 2'd0, 1'b1);
    end else begin
      // edge: two end nodes, two adjacent faces
      push_incidence(KIND_NODE, grid_point(i, j, dx), ORI_NONE, 2'd0, 1'b0);
      if (t == 0)
        push_incidence(KIND_NODE, grid_point(ip, j, dx), ORI_NONE, 2'd0, node_sel);
      else
        push_incidence(KIND_NODE, grid_point(i, jp, dx), ORI_NONE, 2'd0, node_sel);
      if (node_sel)
        return;
      face_ids[0] = grid_point(i, j, dx);
      // the lower or left neighbour always wraps, even without periodic wrap
      if (t == 0)
        face_ids[1] = grid_point(i, (j + dy - 1) % dy, dx);
      else
        face_ids[1] = grid_point((i + dx - 1) % dx, j, dx);
      for (p = 0; p < 2; p++)
        push_incidence(KIND_FACE, face_ids[p], EDGE_FACE_ORI[t][p],
                       EDGE_FACE_SLOT[t][p], p == 1);
    end
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Check each result word against the oldest expectation
  always @(posedge clk) begin : check_result
    incidence_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_checked++;
      if (incidence_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual kind %0d id %0d",
                 $time, out_tuser, out_tdata[20:0]);
        errors++;
      end else begin
        want = incidence_q.pop_front();
        check_field("kind", want.kind, out_tuser);
        check_field("ref_id", want.ref_id, out_tdata[20:0]);
        check_field("orientation", want.ori, $signed(out_tdata[22:21]));
        check_field("local_slot", want.slot, out_tdata[24:23]);
        check_field("last", want.last, out_tlast);
        check_field("pad", 0, out_tdata[31:25]);
      end
    end
  end

  // Send one query word, with an optional idle burst ahead of it
  task automatic send_query(logic cmd, logic [ID_W-1:0] id, logic node_sel);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {2'b00, node_sel, id};
    do @(posedge clk); while (!in_tready);
    predict_incidence(cmd, id, node_sel);
  endtask

  // Hold the input and wait until every expected word has come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (incidence_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [DIM_REG_W-1:0] val);
    @(negedge clk);
    in_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIM_X:  grid_dim_x = val;
      CFG_DIM_Y:  grid_dim_y = val;
      CFG_WRAP_X: grid_wrap_x = val[0];
      CFG_WRAP_Y: grid_wrap_y = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reprogram the whole grid once the block is idle; upper wrap bits are noise
  task automatic set_grid(int dx, int dy, bit wx, bit wy);
    wait_drained();
    write_reg(CFG_DIM_X, DIM_REG_W'(dx));
    write_reg(CFG_DIM_Y, DIM_REG_W'(dy));
    write_reg(CFG_WRAP_X, {(DIM_REG_W-1)'($urandom), wx});
    write_reg(CFG_WRAP_Y, {(DIM_REG_W-1)'($urandom), wy});
    grids_used++;
  endtask

  // Mostly in-range positions, some anywhere up to one row past the grid, a few raw ids
  task automatic send_random_query();
    int dx, dy, lim_x, lim_y, pos, mode;
    logic cmd, node_sel;
    logic [ID_W-1:0] id;
    dx = eff_dim(grid_dim_x);
    dy = eff_dim(grid_dim_y);
    lim_x = grid_wrap_x ? dx : dx - 1;
    lim_y = grid_wrap_y ? dy : dy - 1;
    cmd = 1'($urandom_range(0, 1));
    node_sel = ($urandom_range(0, 3) == 0);
    mode = $urandom_range(0, 9);
    if (mode < 7 && lim_x > 0 && lim_y > 0)
      pos = $urandom_range(0, lim_x - 1) + dx * $urandom_range(0, lim_y - 1);
    else
      pos = $urandom_range(0, dx * dy + dx);
    if (mode == 9)
      id = ID_W'($urandom);
    else
      id = cmd ? ID_W'(2 * pos + $urandom_range(0, 1)) : ID_W'(pos);
    send_query(cmd, id, node_sel);
  endtask

  // Reset values: full 1024 x 1024 grid, no wrap
  task automatic test_reset_grid();
    send_query(1'b0, 21'd0, 1'b0);
    send_query(1'b0, 21'd0, 1'b1);
    send_query(1'b1, 21'd0, 1'b0);
    send_query(1'b1, 21'd1, 1'b0);
    send_query(1'b0, ID_W'(1022 + 1024 * 1022), 1'b0);
    send_query(1'b0, 21'd1023, 1'b0);
    send_query(1'b0, 21'h1FFFFF, 1'b0);
    send_query(1'b1, 21'h1FFFFF, 1'b1);
  endtask

  // Small grid with and without wrap, neighbours across the seam
  task automatic test_small_grid();
    set_grid(5, 4, 1'b1, 1'b1);
    send_query(1'b0, 21'd19, 1'b0);
    send_query(1'b0, 21'd19, 1'b1);
    send_query(1'b1, 21'd4, 1'b0);
    send_query(1'b1, 21'd21, 1'b0);
    send_query(1'b1, 21'd39, 1'b1);
    set_grid(5, 4, 1'b0, 1'b0);
    send_query(1'b1, 21'd11, 1'b0);
    send_query(1'b0, 21'd4, 1'b0);
    send_query(1'b1, 21'd0, 1'b0);
  endtask

  // Zero, single-point and oversized dimensions
  task automatic test_degenerate_grid();
    set_grid(0, 7, 1'b1, 1'b1);
    send_query(1'b0, 21'd0, 1'b0);
    send_query(1'b1, 21'd1, 1'b0);
    set_grid(1, 1, 1'b1, 1'b1);
    send_query(1'b0, 21'd0, 1'b0);
    send_query(1'b1, 21'd1, 1'b0);
    send_query(1'b1, 21'd0, 1'b0);
    set_grid(2047, 3, 1'b0, 1'b0);
    send_query(1'b0, 21'd2046, 1'b0);
    send_query(1'b0, 21'd1023, 1'b0);
  endtask

  // Random phases over fixed extremes first, then random grids
  task automatic test_random_grids();
    int p, n, dx, dy;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin dx = 1024; dy = 1024; end
        1: begin dx = 2047; dy = 2047; end
        2: begin dx = 1;    dy = 2;    end
        3: begin dx = 2;    dy = 1;    end
        default: begin
          dx = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, 40);
          dy = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, 40);
        end
      endcase
      set_grid(dx, dy, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      // the last phase and every third one run without idling
      idle_on = (p != PHASES - 1) && (p % 3 != 2);
      for (n = 0; n < PHASE_ITEMS; n++)
        send_random_query();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    idle_on = 1'b1;
    test_reset_grid();
    test_small_grid();
    test_degenerate_grid();
    test_random_grids();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d queries (%0d invalid) over %0d grid settings,", queries_sent,
             bad_queries, grids_used);
    $display("checked %0d result words with random idling on both sides.", words_checked);
    if (errors == 0)
      $display("grid_mesh_incidence_query verification clean");
    else
      $display("grid_mesh_incidence_query verification failed");
    $finish;
  end

endmodule
